/* hw/rtl/mprf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mprf_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 256;
  localparam int PORT_COUNT = 4;
  localparam int MAX_READ   = 64;

  // Derived widths.
  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int LEN_W    = PTR_W + 1;
  localparam int PIDX_W   = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int STORE_AW = $clog2(PORT_COUNT * RING_DEPTH);
  localparam int LIM_W    = $clog2(MAX_READ + 1);

  // Command queue between front and back.
  localparam int CMDQ_DEPTH = 2;

  // Operation codes on the input channel.
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_QUERY,
    CMD_READ
  } cmd_kind_t;

  // One classified command as it travels through the queue.
  typedef struct packed {
    cmd_kind_t          kind;
    logic               port_ok;
    logic [PIDX_W-1:0]  idx;
    logic [7:0]         data;
    logic [LIM_W-1:0]   lim;
  } cmd_t;

  // Advance a ring pointer with wrap at the ring depth.
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  // Flat address of a ring slot in the shared byte store.
  function automatic logic [STORE_AW-1:0] store_addr(input logic [PIDX_W-1:0] idx,
                                                     input logic [PTR_W-1:0] ptr);
    return STORE_AW'(idx) * STORE_AW'(RING_DEPTH) + STORE_AW'(ptr);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mprf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mprf_front (
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // data[7:0], max_len[14:8], zero[15]
  input  wire logic [3:0]        in_tuser,   // operation[1:0], port[3:2]
  output logic                   q_valid,
  input  wire logic              q_ready,
  output mprf_pkg::cmd_t         q_cmd
);
  import mprf_pkg::*;

  logic [1:0] op;
  logic [1:0] port;
  logic [6:0] max_len;
  logic       port_ok;
  logic       keep;

  assign op      = in_tuser[1:0];
  assign port    = in_tuser[3:2];
  assign max_len = in_tdata[14:8];
  assign port_ok = 32'(port) < PORT_COUNT;

  // Items that change nothing and give no result are taken and dropped here.
  assign in_tready = q_ready;
  assign q_valid   = in_tvalid && keep;

  // Classify the beat and saturate the read limit.
  always_comb begin
    keep          = 1'b0;
    q_cmd.kind    = CMD_PUSH;
    q_cmd.port_ok = port_ok;
    q_cmd.idx     = PIDX_W'(port);
    q_cmd.data    = in_tdata[7:0];
    if (32'(max_len) > MAX_READ) begin
      q_cmd.lim = LIM_W'(MAX_READ);
    end else begin
      q_cmd.lim = LIM_W'(max_len);
    end
    unique case (op)
      OP_PUSH: begin
        keep       = port_ok;
        q_cmd.kind = CMD_PUSH;
      end
      OP_QUERY: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_QUERY;
      end
      OP_READ: begin
        keep       = 1'b1;
        q_cmd.kind = CMD_READ;
      end
      default: begin
        keep       = 1'b0;
        q_cmd.kind = CMD_PUSH;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/mprf_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module mprf_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire mprf_pkg::cmd_t wr_cmd,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output mprf_pkg::cmd_t      rd_cmd
);
  import mprf_pkg::*;

  localparam int AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slot_r [CMDQ_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = cnt_r != CW'(CMDQ_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_cmd   = slot_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointer and fill count updates.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == AW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == AW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue slots carry payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wp_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mprf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mprf_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire mprf_pkg::cmd_t q_cmd,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [15:0]         out_tdata,   // data_byte[7:0], count[15:8]
  output logic                out_tuser,   // byte_valid
  output logic                out_tlast
);
  import mprf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DATA
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wptr_r [PORT_COUNT];
  logic [PTR_W-1:0]   wptr_nxt [PORT_COUNT];
  logic [PTR_W-1:0]   rptr_r [PORT_COUNT];
  logic [PTR_W-1:0]   rptr_nxt [PORT_COUNT];
  logic [PIDX_W-1:0]  cur_idx_r, cur_idx_nxt;
  logic [LIM_W-1:0]   cur_lim_r, cur_lim_nxt;
  logic [LIM_W-1:0]   k_r, k_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic [7:0]         out_cnt_r, out_cnt_nxt;
  logic               out_bv_r, out_bv_nxt;
  logic               out_last_r, out_last_nxt;

  // Byte store and its ports.
  logic [7:0]          store_mem [PORT_COUNT * RING_DEPTH];
  logic [7:0]          rd_data_r;
  logic                mem_we;
  logic                mem_re;
  logic [STORE_AW-1:0] wr_addr;
  logic [STORE_AW-1:0] rd_addr;

  logic               slot_free;
  logic [PTR_W-1:0]   q_w;
  logic [PTR_W-1:0]   q_r;
  logic [PTR_W-1:0]   q_wn;
  logic [LEN_W-1:0]   q_len;
  logic [PTR_W-1:0]   c_r;
  logic [PTR_W-1:0]   c_rn;
  logic [LIM_W-1:0]   k_inc;

  assign slot_free = !out_valid_r || out_tready;
  assign q_ready   = (state_r == ST_IDLE) && ((q_cmd.kind == CMD_PUSH) || slot_free);

  assign q_w   = wptr_r[q_cmd.idx];
  assign q_r   = rptr_r[q_cmd.idx];
  assign q_wn  = ring_next(q_w);
  assign q_len = {1'b0, q_w} - {1'b0, q_r}
               + ((q_w < q_r) ? LEN_W'(RING_DEPTH) : LEN_W'(0));
  assign c_r   = rptr_r[cur_idx_r];
  assign c_rn  = ring_next(c_r);
  assign k_inc = k_r + LIM_W'(1);

  assign wr_addr = store_addr(q_cmd.idx, q_w);
  assign rd_addr = store_addr(cur_idx_r, c_r);
  assign mem_re  = state_r == ST_ISSUE;

  // Command execution and read sequencing.
  always_comb begin
    state_nxt     = state_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    cur_idx_nxt   = cur_idx_r;
    cur_lim_nxt   = cur_lim_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_cnt_nxt   = out_cnt_r;
    out_bv_nxt    = out_bv_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_ready) begin
          unique case (q_cmd.kind)
            CMD_PUSH: begin
              // A full ring drops its oldest byte first.
              mem_we                = 1'b1;
              wptr_nxt[q_cmd.idx]   = q_wn;
              if (q_wn == q_r) begin
                rptr_nxt[q_cmd.idx] = ring_next(q_r);
              end
            end
            CMD_QUERY: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = '0;
              out_bv_nxt    = 1'b0;
              out_last_nxt  = 1'b1;
              if (!q_cmd.port_ok) begin
                out_cnt_nxt = '0;
              end else if (32'(q_len) > 32'd255) begin
                out_cnt_nxt = 8'd255;
              end else begin
                out_cnt_nxt = 8'(q_len);
              end
            end
            CMD_READ: begin
              if (!q_cmd.port_ok || (q_cmd.lim == '0) || (q_w == q_r)) begin
                out_valid_nxt = 1'b1;
                out_byte_nxt  = '0;
                out_cnt_nxt   = '0;
                out_bv_nxt    = 1'b0;
                out_last_nxt  = 1'b1;
              end else begin
                cur_idx_nxt = q_cmd.idx;
                cur_lim_nxt = q_cmd.lim;
                k_nxt       = '0;
                state_nxt   = ST_ISSUE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (slot_free) begin
          out_valid_nxt       = 1'b1;
          out_byte_nxt        = rd_data_r;
          out_cnt_nxt         = 8'(k_inc);
          out_bv_nxt          = 1'b1;
          out_last_nxt        = (k_inc == cur_lim_r) || (c_rn == wptr_r[cur_idx_r]);
          rptr_nxt[cur_idx_r] = c_rn;
          k_nxt               = k_inc;
          state_nxt           = out_last_nxt ? ST_IDLE : ST_ISSUE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, ring pointers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        wptr_r[i] <= '0;
        rptr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
    end
    cur_idx_r  <= cur_idx_nxt;
    cur_lim_r  <= cur_lim_nxt;
    k_r        <= k_nxt;
    out_byte_r <= out_byte_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_bv_r   <= out_bv_nxt;
    out_last_r <= out_last_nxt;
  end

  // Shared byte store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_addr] <= q_cmd.data;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_byte_r};
  assign out_tuser  = out_bv_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

/* hw/rtl/multi_port_rx_ring_fifo_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// A query or an empty read gives its result via the command queue and the output register;
// a read passes the command queue, then the sequencer fetches one byte at a time, each issued
// to the byte store's registered read port in ST_ISSUE and registered for output in ST_DATA.
// Throughput: pushes and queries sustain one beat per cycle unless a read or output stall holds.
// Reset: rst_n is synchronous, active low; it empties every ring and the command queue.
// The byte store itself is not cleared and needs no clearing pass.

module multi_port_rx_ring_fifo_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // data[7:0], max_len[14:8], zero[15]
  input  wire logic [3:0]  in_tuser,    // operation[1:0], port[3:2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // data_byte[7:0], count[15:8]
  output logic             out_tuser,   // byte_valid
  output logic             out_tlast
);
  import mprf_pkg::*;

  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic bq_valid;
  logic bq_ready;
  cmd_t bq_cmd;

  // Front end: accept and classify input beats.
  mprf_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_cmd     (fq_cmd)
  );

  // Short command queue between the two halves.
  mprf_cmd_fifo u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (bq_valid),
    .rd_ready (bq_ready),
    .rd_cmd   (bq_cmd)
  );

  // Back end: rings, byte store and result generation.
  mprf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_cmd      (bq_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

/* hw/rtl/mprf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mprf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // A beat without a drained byte is always the only and final one of its item.
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("result without byte is not marked last");

  // A beat without a drained byte carries a zero data byte.
  a_nobyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("result without byte has nonzero data");

  // A drained byte always counts at least itself.
  a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:8] != 8'd0)
    else $error("drained byte with zero count");

endmodule

bind multi_port_rx_ring_fifo_top mprf_checker u_mprf_checker (.*);

`default_nettype wire

/* dv/tb_multi_port_rx_ring_fifo_top.sv */
`timescale 1ns / 1ps

module tb_multi_port_rx_ring_fifo_top;
  import mprf_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 180;
  localparam int TAIL_CYCLES  = 16;
  localparam int LONG_HOLD    = 400;
  localparam int HOLD_START   = 500;
  localparam int MAX_REPORTS  = 10;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] port;
    logic [7:0] data;
    logic [6:0] max_len;
  } ring_cmd_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] count;
    logic       byte_valid;
    logic       last;
  } ring_result_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_BUSY,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [3:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  // Commands still to be sent, and results that the rings are due to return.
  ring_cmd_t    cmd_q[$];
  ring_result_t ring_result_q[$];

  // Shadow copy of the rings.
  logic [7:0] ring_mem [PORT_COUNT][RING_DEPTH];
  int         ring_wr  [PORT_COUNT];
  int         ring_rd  [PORT_COUNT];

  int       in_beats    = 0;
  int       in_retired  = 0;
  int       idle_cycles = 0;
  int       err_cnt     = 0;
  int       send_burst  = 1;
  int       send_gap    = 0;
  int       rx_cycle    = 0;
  int       rx_hold     = 0;
  rx_mode_t rx_mode     = RX_FREE;

  multi_port_rx_ring_fifo_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int wrap_inc(int ptr);
    return (ptr + 1 >= RING_DEPTH) ? 0 : ptr + 1;
  endfunction

  function automatic int ring_len(int p);
    if (ring_wr[p] >= ring_rd[p]) begin
      return ring_wr[p] - ring_rd[p];
    end
    return RING_DEPTH - ring_rd[p] + ring_wr[p];
  endfunction

  function automatic ring_result_t make_result(int b, int cnt, logic valid, logic lst);
    ring_result_t r;
    r.data_byte  = 8'(b);
    r.count      = (cnt > 255) ? 8'd255 : 8'(cnt);
    r.byte_valid = valid;
    r.last       = lst;
    return r;
  endfunction

  // Update the shadow rings for one accepted command and queue its results.
  task automatic ring_apply(ring_cmd_t c);
    int p;
    int lim;
    int k;
    int b;
    p   = int'(c.port);
    lim = int'(c.max_len);
    k   = 0;
    case (c.op)
      OP_PUSH: begin
        if (p < PORT_COUNT) begin
          // A full ring drops its oldest byte to make room.
          if (wrap_inc(ring_wr[p]) == ring_rd[p]) begin
            ring_rd[p] = wrap_inc(ring_rd[p]);
          end
          ring_mem[p][ring_wr[p]] = c.data;
          ring_wr[p] = wrap_inc(ring_wr[p]);
        end
      end
      OP_QUERY: begin
        ring_result_q.push_back(make_result(0, (p < PORT_COUNT) ? ring_len(p) : 0,
                                            1'b0, 1'b1));
      end
      OP_READ: begin
        if (lim > MAX_READ) begin
          lim = MAX_READ;
        end
        if (p < PORT_COUNT) begin
          while (ring_rd[p] != ring_wr[p] && k < lim) begin
            b = int'(ring_mem[p][ring_rd[p]]);
            ring_rd[p] = wrap_inc(ring_rd[p]);
            k++;
            ring_result_q.push_back(make_result(b, k, 1'b1,
                                                ring_rd[p] == ring_wr[p] || k == lim));
          end
        end
        // Nothing drained still gives one closing result.
        if (k == 0) begin
          ring_result_q.push_back(make_result(0, 0, 1'b0, 1'b1));
        end
      end
      default: ;
    endcase
  endtask

  function automatic void add_cmd(logic [1:0] op, int port, int data, int len);
    ring_cmd_t c;
    c.op      = op;
    c.port    = 2'(port);
    c.data    = 8'(data);
    c.max_len = 7'(len);
    cmd_q.push_back(c);
  endfunction

  // Sender: bursts of beats with random gaps; a beat is held until taken.
  always @(negedge clk) begin
    logic      nv;
    ring_cmd_t c;
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_beats != in_retired) begin
        in_retired = in_beats;
        void'(cmd_q.pop_front());
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_q.size() != 0) begin
          nv = 1'b1;
          c  = cmd_q[0];
          in_tdata <= {1'b0, c.max_len, c.data};
          in_tuser <= {c.port, c.op};
          send_burst--;
          if (send_burst <= 0) begin
            send_burst = $urandom_range(1, 24);
            send_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_tvalid <= nv;
    end
  end

  // Receiver: its own stall pattern, redrawn at random periodically, plus one long hold-off.
  always @(negedge clk) begin
    logic nr;
    rx_cycle++;
    if (rx_cycle == HOLD_START) begin
      rx_hold = LONG_HOLD;
    end
    if (rx_cycle % 64 == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    end
    if (rx_hold > 0) begin
      rx_hold--;
      nr = 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   nr = 1'b1;
        RX_BUSY:   nr = ($urandom_range(0, 99) < 75);
        RX_SPARSE: nr = ($urandom_range(0, 99) < 25);
        default:   nr = (rx_cycle % 3) != 0;
      endcase
    end
    out_tready <= nr;
  end

  // Monitor: predict on every input beat, check every result beat, count idle cycles.
  always @(posedge clk) begin
    ring_cmd_t    c;
    ring_result_t got;
    ring_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.op      = in_tuser[1:0];
        c.port    = in_tuser[3:2];
        c.data    = in_tdata[7:0];
        c.max_len = in_tdata[14:8];
        ring_apply(c);
        in_beats++;
      end
      if (out_tvalid && out_tready) begin
        got.data_byte  = out_tdata[7:0];
        got.count      = out_tdata[15:8];
        got.byte_valid = out_tuser;
        got.last       = out_tlast;
        if (ring_result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("unexpected result beat: data_byte=%02h count=%0d byte_valid=%0b last=%0b",
                     got.data_byte, got.count, got.byte_valid, got.last);
          end
        end else begin
          want = ring_result_q.pop_front();
          if (got.data_byte !== want.data_byte || got.count !== want.count ||
              got.byte_valid !== want.byte_valid || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("mismatch: data_byte exp %02h got %02h, count exp %0d got %0d",
                       want.data_byte, got.data_byte, want.count, got.count);
              $display("          byte_valid exp %0b got %0b, last exp %0b got %0b",
                       want.byte_valid, got.byte_valid, want.last, got.last);
            end
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    int n;
    int kind;
    int port;
    int burst;

    // Directed: empty rings, byte extremes, zero and saturated limits, ignored opcode.
    add_cmd(OP_QUERY, 0, 8'h00, 0);
    add_cmd(OP_READ, 1, 8'h00, 5);
    add_cmd(OP_PUSH, 2, 8'h00, 0);
    add_cmd(OP_PUSH, 2, 8'hFF, 127);
    add_cmd(OP_PUSH, 2, 8'hA5, 0);
    add_cmd(OP_PUSH, 2, 8'h5A, 0);
    add_cmd(OP_QUERY, 2, 8'hFF, 127);
    add_cmd(OP_READ, 2, 8'h00, 0);
    add_cmd(OP_READ, 2, 8'h00, 2);
    add_cmd(OP_READ, 2, 8'hFF, 127);
    add_cmd(OP_NONE, 3, 8'hFF, 127);
    add_cmd(OP_PUSH, 0, 8'h80, 0);
    add_cmd(OP_PUSH, 1, 8'h01, 0);
    add_cmd(OP_PUSH, 3, 8'h7F, 0);
    add_cmd(OP_QUERY, 3, 8'h00, 0);
    add_cmd(OP_READ, 3, 8'h00, 64);
    add_cmd(OP_READ, 0, 8'h00, 1);
    add_cmd(OP_READ, 1, 8'h00, 65);
    add_cmd(OP_QUERY, 3, 8'h00, 0);

    // Overfill one ring so the oldest bytes get dropped, then drain it.
    port = $urandom_range(0, PORT_COUNT - 1);
    for (int i = 0; i < RING_DEPTH + 8; i++) begin
      add_cmd(OP_PUSH, port, $urandom, $urandom);
    end
    add_cmd(OP_QUERY, port, $urandom, $urandom);
    for (int i = 0; i < 5; i++) begin
      add_cmd(OP_READ, port, $urandom, MAX_READ);
    end

    // Random part: mostly push bursts followed by a read, with queries and noise mixed in.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      port = $urandom_range(0, PORT_COUNT - 1);
      if (kind < 50) begin
        burst = $urandom_range(1, 12);
        for (int i = 0; i < burst; i++) begin
          add_cmd(OP_PUSH, port, $urandom, $urandom);
        end
        add_cmd(OP_READ, port, $urandom,
                ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127)
                                            : $urandom_range(0, burst + 2));
        n += burst + 1;
      end else if (kind < 70) begin
        add_cmd(OP_QUERY, port, $urandom, $urandom);
        n++;
      end else if (kind < 85) begin
        add_cmd(OP_READ, port, $urandom, $urandom_range(0, 127));
        n++;
      end else if (kind < 95) begin
        add_cmd(OP_PUSH, port, $urandom, $urandom);
        n++;
      end else begin
        add_cmd(OP_NONE, port, $urandom, $urandom);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Run until every command is taken and every result has come back.
    while (idle_cycles < IDLE_LIMIT &&
           (cmd_q.size() != 0 || in_tvalid || ring_result_q.size() != 0)) begin
      @(posedge clk);
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
      err_cnt++;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end
    if (ring_result_q.size() != 0) begin
      $display("%0d expected result beats never arrived", ring_result_q.size());
      err_cnt += ring_result_q.size();
    end

    if (err_cnt == 0) begin
      $display("** multi_port_rx_ring_fifo_top: PASSED **");
    end else begin
      $display("** multi_port_rx_ring_fifo_top: FAILED **");
    end
    $finish;
  end

endmodule
